>>> design/gfau_pkg.sv
package gfau_pkg;

  localparam int CMD_W    = 3;
  localparam int ELEM_W   = 8;
  localparam int POW_IN_W = 9;
  localparam int ST_W     = 3;
  localparam int DEG_W    = 4;
  localparam int POLY_W   = 9;

  localparam logic [DEG_W-1:0]  DEG_RESET  = 4'd8;
  localparam logic [POLY_W-1:0] POLY_RESET = 9'd285;
  localparam logic [DEG_W-1:0]  MIN_DEGREE = 4'd2;

  // configuration register indexes
  localparam logic CFG_DEGREE = 1'b0;
  localparam logic CFG_POLY   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 3'd0,
    CMD_MUL = 3'd1,
    CMD_DIV = 3'd2,
    CMD_INV = 3'd3,
    CMD_EXP = 3'd4,
    CMD_LOG = 3'd5,
    CMD_INC = 3'd6
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_DIV_ZERO  = 3'd1,
    ST_LOG_ZERO  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_BAD_POLY  = 3'd4
  } status_t;

  // where the final element comes from
  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_ANTILOG,
    KIND_POWER
  } kind_t;

  typedef enum logic [1:0] {
    BLD_CLEAR,
    BLD_GEN,
    BLD_DONE
  } bld_state_t;

endpackage

>>> design/gfau_ram.sv
module gfau_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/galois_field_arithmetic_unit.sv
// Channel  Handshake            Word
// -------  -------------------  ---------------------------------------------
// cfg      cfg_write            cfg_index, cfg_data
// in       in_valid / in_stall  cmd, operand_a, operand_b, power_in
// out      out_valid / out_stall element_out, power_out, status
//
// One word per cycle while in_stall is low; an accepted word passes the log
// lookup, the exponent add and antilog lookup, and the output register before
// it shows on out_valid. After reset and after every config write the tables
// are rebuilt: the log table is cleared, then alpha^i is stepped to fill both
// tables; in_stall is high meanwhile. out_stall holds the output register and
// backs up through the pipeline only as far as there are no empty stages.
module galois_field_arithmetic_unit #(
  parameter int MAX_DEGREE = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [gfau_pkg::POLY_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [gfau_pkg::CMD_W-1:0]    cmd,
  input  logic [gfau_pkg::ELEM_W-1:0]   operand_a,
  input  logic [gfau_pkg::ELEM_W-1:0]   operand_b,
  input  logic [gfau_pkg::POW_IN_W-1:0] power_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gfau_pkg::ELEM_W-1:0]   element_out,
  output logic [gfau_pkg::ELEM_W-1:0]   power_out,
  output logic [gfau_pkg::ST_W-1:0]     status
);

  import gfau_pkg::*;

  localparam int MD    = MAX_DEGREE;
  localparam int DEPTH = 1 << MD;

  // configuration
  logic [DEG_W-1:0]  degree;
  logic [POLY_W-1:0] poly;
  logic [DEG_W-1:0]  m_eff;
  logic [MD-1:0]     n_mask;
  logic [MD-1:0]     top_bit;
  logic [MD-1:0]     poly_low;
  logic              poly_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree <= DEG_RESET;
      poly   <= POLY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEGREE: degree <= cfg_data[DEG_W-1:0];
        CFG_POLY:   poly   <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (degree < MIN_DEGREE) begin
      m_eff = MIN_DEGREE;
    end else if (degree > DEG_W'(MD)) begin
      m_eff = DEG_W'(MD);
    end else begin
      m_eff = degree;
    end
  end

  assign n_mask   = ~({MD{1'b1}} << m_eff);
  assign top_bit  = n_mask & ~(n_mask >> 1);
  assign poly_low = poly[MD-1:0] & n_mask;
  assign poly_ok  = poly[m_eff];

  // table builder
  bld_state_t    bld_state, bld_next;
  logic [MD-1:0] cnt;
  logic [MD-1:0] gen_elem;
  logic [MD-1:0] elem_next;
  logic          carry;
  logic          tables_ready;
  logic          log_we, alog_we;
  logic [MD-1:0] log_waddr, log_wdata, alog_waddr, alog_wdata;

  assign carry     = |(gen_elem & top_bit);
  assign elem_next = ((gen_elem << 1) & n_mask) ^ (carry ? poly_low : '0);

  always_comb begin
    bld_next = bld_state;
    unique case (bld_state)
      BLD_CLEAR: if (cnt == n_mask) bld_next = BLD_GEN;
      BLD_GEN:   if (cnt == n_mask - MD'(1)) bld_next = BLD_DONE;
      BLD_DONE:  bld_next = BLD_DONE;
    endcase
    // any register change restarts the rebuild
    if (cfg_write) bld_next = BLD_CLEAR;
  end

  always_comb begin
    log_we       = 1'b0;
    log_waddr    = cnt;
    log_wdata    = '0;
    alog_we      = 1'b0;
    alog_waddr   = cnt;
    alog_wdata   = gen_elem;
    tables_ready = 1'b0;
    unique case (bld_state)
      BLD_CLEAR: begin
        log_we = 1'b1;
      end
      BLD_GEN: begin
        log_we    = 1'b1;
        log_waddr = gen_elem;
        log_wdata = cnt;
        alog_we   = 1'b1;
      end
      BLD_DONE: begin
        tables_ready = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bld_state <= BLD_CLEAR;
      cnt       <= '0;
      gen_elem  <= MD'(1);
    end else begin
      bld_state <= bld_next;
      if (cfg_write || bld_state != bld_next) begin
        cnt      <= '0;
        gen_elem <= MD'(1);
      end else if (bld_state != BLD_DONE) begin
        cnt <= cnt + MD'(1);
        if (bld_state == BLD_GEN) gen_elem <= elem_next;
      end
    end
  end

  // pipeline control
  logic v1, v2;
  logic en1, en2, en3;
  logic take;

  assign en3      = !out_valid || !out_stall;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_stall = !en1 || !tables_ready;
  assign take     = in_valid && !in_stall;

  // stage 0: decode and check
  cmd_t              c0;
  status_t           st0;
  kind_t             kind0;
  logic [ELEM_W-1:0] direct0;
  logic [ELEM_W-1:0] n_elem;
  logic              a_hi, b_hi, pw_hi;

  assign c0     = cmd_t'(cmd);
  assign n_elem = ELEM_W'(n_mask);
  assign a_hi   = |(operand_a & ~n_elem);
  assign b_hi   = |(operand_b & ~n_elem);
  assign pw_hi  = power_in >= POW_IN_W'({n_mask, 1'b0});

  always_comb begin
    st0     = ST_OK;
    kind0   = KIND_DIRECT;
    direct0 = '0;
    if (!poly_ok) begin
      st0 = ST_BAD_POLY;
    end else begin
      unique case (c0)
        CMD_ADD: begin
          if (a_hi || b_hi) st0 = ST_RANGE;
          else direct0 = operand_a ^ operand_b;
        end
        CMD_MUL: begin
          if (a_hi || b_hi) st0 = ST_RANGE;
          else if (operand_a != '0 && operand_b != '0) kind0 = KIND_ANTILOG;
        end
        CMD_DIV: begin
          if (a_hi || b_hi) st0 = ST_RANGE;
          else if (operand_b == '0) st0 = ST_DIV_ZERO;
          else if (operand_a != '0) kind0 = KIND_ANTILOG;
        end
        CMD_INV: begin
          if (a_hi) st0 = ST_RANGE;
          else if (operand_a == '0) st0 = ST_DIV_ZERO;
          else kind0 = KIND_ANTILOG;
        end
        CMD_EXP: begin
          if (pw_hi) st0 = ST_RANGE;
          else kind0 = KIND_ANTILOG;
        end
        CMD_LOG: begin
          if (a_hi) st0 = ST_RANGE;
          else if (operand_a == '0) st0 = ST_LOG_ZERO;
          else kind0 = KIND_POWER;
        end
        CMD_INC: begin
          if (a_hi) st0 = ST_RANGE;
          else if (operand_a == '0) direct0 = ELEM_W'(1);
          else kind0 = KIND_ANTILOG;
        end
        default: st0 = ST_RANGE;
      endcase
    end
  end

  // stage 1: log lookups
  status_t           st1;
  kind_t             kind1;
  logic [ELEM_W-1:0] direct1;
  cmd_t              cmd1;
  logic [MD:0]       pw1;
  logic [MD-1:0]     la, lb;

  gfau_ram #(.WIDTH(MD), .DEPTH(DEPTH)) u_log_a (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (log_wdata),
    .re    (en1),
    .raddr (operand_a[MD-1:0]),
    .rdata (la)
  );

  gfau_ram #(.WIDTH(MD), .DEPTH(DEPTH)) u_log_b (
    .clk   (clk),
    .we    (log_we),
    .waddr (log_waddr),
    .wdata (log_wdata),
    .re    (en1),
    .raddr (operand_b[MD-1:0]),
    .rdata (lb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      st1     <= st0;
      kind1   <= kind0;
      direct1 <= direct0;
      cmd1    <= c0;
      pw1     <= power_in[MD:0];
    end
  end

  // exponent sum, reduced once modulo n
  logic [MD:0]   x1;
  logic [MD:0]   n_ext;
  logic [MD-1:0] e1;

  assign n_ext = (MD+1)'(n_mask);

  always_comb begin
    unique case (cmd1)
      CMD_DIV: x1 = (MD+1)'(la) + (MD+1)'(n_mask - lb);
      CMD_INV: x1 = (MD+1)'(n_mask - la);
      CMD_EXP: x1 = pw1;
      CMD_INC: x1 = (MD+1)'(la) + (MD+1)'(1);
      default: x1 = (MD+1)'(la) + (MD+1)'(lb);
    endcase
  end

  assign e1 = (x1 >= n_ext) ? MD'(x1 - n_ext) : MD'(x1);

  // stage 2: antilog lookup
  status_t           st2;
  kind_t             kind2;
  logic [ELEM_W-1:0] direct2;
  logic [ELEM_W-1:0] pout2;
  logic [MD-1:0]     alog_q;

  gfau_ram #(.WIDTH(MD), .DEPTH(DEPTH)) u_antilog (
    .clk   (clk),
    .we    (alog_we),
    .waddr (alog_waddr),
    .wdata (alog_wdata),
    .re    (en2),
    .raddr (e1),
    .rdata (alog_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      st2     <= st1;
      kind2   <= kind1;
      direct2 <= direct1;
      pout2   <= ELEM_W'(la);
    end
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      status <= st2;
      unique case (kind2)
        KIND_ANTILOG: element_out <= ELEM_W'(alog_q);
        KIND_DIRECT:  element_out <= direct2;
        default:      element_out <= '0;
      endcase
      power_out <= (kind2 == KIND_POWER) ? pout2 : '0;
    end
  end

`ifndef SYNTH
  a_build_stall: assert property (@(posedge clk) disable iff (rst)
    !tables_ready |-> in_stall)
    else $error("word accepted while tables are being rebuilt");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> bld_state == BLD_CLEAR)
    else $error("config write did not restart the table rebuild");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> element_out == '0 && power_out == '0)
    else $error("error result carries a nonzero element or power");

  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !en3 |=> v2 && $stable(st2) && $stable(kind2))
    else $error("stage 2 word changed while the output was stalled");
`endif

endmodule
